@@ rtl/pfx_pkg.sv @@
// Package: shared types, codes and constants for the postfix evaluator.
`default_nettype none

package pfx_pkg;

    // Data path and stack sizing
    localparam int DATA_W            = 32;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int STEP_W            = $clog2(DATA_W + 1);

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FEW       = 3'd1,
        STAT_MALFORMED = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_DIVZERO   = 3'd4,
        STAT_OVERFLOW  = 3'd5
    } status_t;

    // Arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // Input beat
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expr;
    } expr_t;

    // Output beat
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [2:0]               status;
    } result_t;

    // Request into the arithmetic unit
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    // Response from the arithmetic unit
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/pfx_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/pfx_alu.sv @@
// Iterative arithmetic unit: one shared adder for add, sub, shift-add multiply
// and restoring divide.
`default_nettype none

module pfx_alu import pfx_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire alu_req_t          req,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    output alu_rsp_t               rsp
);

    alu_op_t           op_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              neg_reg;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] work_reg, work_next;
    logic [DATA_W-1:0] opnd_reg, opnd_next;

    logic [DATA_W-1:0] add_x;
    logic [DATA_W-1:0] add_y;
    logic              add_sub;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] abs_a;
    logic [DATA_W-1:0] abs_b;
    logic              short_op;

    assign abs_a    = a[DATA_W-1] ? (~a + 1'b1) : a;
    assign abs_b    = b[DATA_W-1] ? (~b + 1'b1) : b;
    assign short_op = (req.op == ALU_ADD) || (req.op == ALU_SUB);
    assign shifted  = {acc_reg[DATA_W-2:0], work_reg[DATA_W-1]};

    // Shared adder operand select
    always_comb
    begin
        add_x   = acc_reg;
        add_y   = opnd_reg;
        add_sub = 1'b0;
        case (op_reg)
            ALU_ADD: add_sub = 1'b0;
            ALU_SUB: add_sub = 1'b1;
            ALU_MUL: add_sub = 1'b0;
            ALU_DIV:
            begin
                add_x   = shifted;
                add_sub = 1'b1;
            end
            default: add_sub = 1'b0;
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}} + (DATA_W+1)'(add_sub);

    // Step and start logic
    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        work_next = work_reg;
        opnd_next = opnd_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next  = short_op ? STEP_W'(1) : STEP_W'(DATA_W);
            acc_next  = short_op ? a : '0;
            work_next = (req.op == ALU_DIV) ? abs_a : a;
            opnd_next = (req.op == ALU_DIV) ? abs_b : b;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_W'(1));
            case (op_reg)
                ALU_ADD, ALU_SUB:
                begin
                    acc_next = sum[DATA_W-1:0];
                end
                ALU_MUL:
                begin
                    if (work_reg[0])
                    begin
                        acc_next = sum[DATA_W-1:0];
                    end
                    opnd_next = {opnd_reg[DATA_W-2:0], 1'b0};
                    work_next = {1'b0, work_reg[DATA_W-1:1]};
                end
                ALU_DIV:
                begin
                    // carry out set means no borrow: the divisor fits
                    acc_next  = sum[DATA_W] ? sum[DATA_W-1:0] : shifted;
                    work_next = {work_reg[DATA_W-2:0], sum[DATA_W]};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand and working registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
        end
        acc_reg  <= acc_next;
        work_reg <= work_next;
        opnd_reg <= opnd_next;
    end

    // Result: quotient gets its sign back, everything else is the accumulator
    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == ALU_DIV)
                      ? (neg_reg ? (~work_reg + 1'b1) : work_reg)
                      : acc_reg;

endmodule

`default_nettype wire

@@ rtl/postfix_expression_evaluator.sv @@
// Top level: postfix expression evaluator with operand stack and sequencer.
//
//   channel  | direction | handshake                     | beat
//   ---------+-----------+-------------------------------+------------------------------
//   expr     | in        | expr_valid / expr_ready       | expr_t: char_code, end_of_expr
//   result   | out       | result_valid / result_ready   | result_t: value, status
//
// A digit or ignored character passes through the decode and finish steps before
// ready rises again. An operator also passes through load and exec; exec runs
// the shared add/shift unit for 32 steps on * and /. An error exits to finish
// from decode, or from load on a zero divisor. The final character waits in finish
// while the output register is still full. Reset clears the count, error and handshake
// state; the stack RAM is not cleared since only written entries are read.
`default_nettype none

module postfix_expression_evaluator import pfx_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    expr_valid,
    output logic         expr_ready,
    input  wire expr_t   expr_data,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result_data
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    state_t            state_reg, state_next;
    logic [7:0]        char_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           err_reg, err_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_data_reg, result_data_next;

    logic              is_digit;
    logic              is_op;
    alu_op_t           dec_op;
    logic              err_none;
    logic              stack_full;
    logic              too_few;
    logic              div_zero;
    logic              out_free;
    logic [CNT_W-1:0]  count_m2;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [DATA_W-1:0] ram_rd_data;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    // Character decode
    assign is_digit = char_reg inside {[CH_ZERO:CH_NINE]};

    always_comb
    begin
        is_op  = 1'b1;
        dec_op = ALU_ADD;
        case (char_reg)
            CH_PLUS:  dec_op = ALU_ADD;
            CH_MINUS: dec_op = ALU_SUB;
            CH_STAR:  dec_op = ALU_MUL;
            CH_SLASH: dec_op = ALU_DIV;
            default:  is_op  = 1'b0;
        endcase
    end

    assign err_none   = (err_reg == STAT_OK);
    assign stack_full = (count_reg >= CNT_W'(STACK_DEPTH));
    assign too_few    = (count_reg < CNT_W'(2));
    assign div_zero   = (dec_op == ALU_DIV) && (tos_reg == '0);
    assign out_free   = !result_valid_reg || result_ready;
    assign count_m2   = count_reg - CNT_W'(2);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (expr_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (err_none && is_op && !too_few)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_LOAD:
            begin
                state_next = div_zero ? ST_FINISH : ST_EXEC;
            end
            ST_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath controls and register updates
    always_comb
    begin
        count_next        = count_reg;
        err_next          = err_reg;
        tos_next          = tos_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = count_reg[ADDR_W-1:0];
        ram_wr_data       = tos_reg;
        ram_rd_en         = 1'b0;
        alu_req.start     = 1'b0;
        alu_req.op        = dec_op;
        result_valid_next = result_valid_reg && !result_ready;
        result_data_next  = result_data_reg;
        case (state_reg)
            ST_DECODE:
            begin
                if (err_none && is_digit)
                begin
                    if (stack_full)
                    begin
                        err_next = STAT_OVERFLOW;
                    end
                    else
                    begin
                        // push the digit, it also becomes top of stack
                        ram_wr_en   = 1'b1;
                        ram_wr_data = DATA_W'(char_reg[3:0]);
                        tos_next    = DATA_W'(char_reg[3:0]);
                        count_next  = count_reg + 1'b1;
                    end
                end
                else if (err_none && is_op)
                begin
                    if (too_few)
                    begin
                        err_next = STAT_FEW;
                    end
                    else
                    begin
                        // b sits in tos_reg, fetch a from the RAM
                        ram_rd_en = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                if (div_zero)
                begin
                    err_next   = STAT_DIVZERO;
                    count_next = count_m2;
                end
                else
                begin
                    alu_req.start = 1'b1;
                end
            end
            ST_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = count_m2[ADDR_W-1:0];
                    ram_wr_data = alu_rsp.result;
                    tos_next    = alu_rsp.result;
                    count_next  = count_reg - 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (last_reg && out_free)
                begin
                    result_valid_next      = 1'b1;
                    result_data_next.value = '0;
                    if (!err_none)
                    begin
                        result_data_next.status = err_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        result_data_next.status = STAT_EMPTY;
                    end
                    else if (count_reg > CNT_W'(1))
                    begin
                        result_data_next.status = STAT_MALFORMED;
                    end
                    else
                    begin
                        result_data_next.status = STAT_OK;
                        result_data_next.value  = tos_reg;
                    end
                    count_next = '0;
                    err_next   = STAT_OK;
                end
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            err_reg          <= STAT_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (expr_valid && expr_ready)
        begin
            char_reg <= expr_data.char_code;
            last_reg <= expr_data.end_of_expr;
        end
        tos_reg         <= tos_next;
        result_data_reg <= result_data_next;
    end

    // Operand stack
    pfx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (count_m2[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Shared arithmetic unit: a from the stack, b from top of stack
    pfx_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (ram_rd_data),
        .b     (tos_reg),
        .rsp   (alu_rsp)
    );

    assign expr_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

`default_nettype wire

@@ bench/tb_postfix_expression_evaluator.sv @@
// Testbench: random and directed postfix expressions checked against a stack model.
module tb_postfix_expression_evaluator;
    import pfx_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int NUM_ITEMS   = 1850;
    localparam int QUIET_TAIL  = 250;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 60;

    // One pending character; drain holds it back until all results are in
    typedef struct packed {
        expr_t beat;
        logic  drain;
    } char_item_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    expr_valid   = 1'b0;
    logic    expr_ready;
    expr_t   expr_data    = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result_data;

    postfix_expression_evaluator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .expr_valid   (expr_valid),
        .expr_ready   (expr_ready),
        .expr_data    (expr_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    always #5 clk = ~clk;

    // Operand stack model and expected results
    logic [31:0] calc_stack [DEPTH];
    int unsigned calc_depth = 0;
    logic [2:0]  calc_err   = STAT_OK;
    result_t     expected_results [$];

    char_item_t  pending [$];
    int unsigned expr_count   = 0;
    int unsigned chars_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned status_seen [8];
    int unsigned cycle_count  = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_stall   = 0;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_op_char(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
    endfunction

    // a op b, 32-bit wrap; division truncates toward zero
    function automatic logic [31:0] apply_operator(logic [7:0] op, logic [31:0] a,
                                                   logic [31:0] b);
        logic [31:0] a_mag;
        logic [31:0] b_mag;
        logic [31:0] quo;
        a_mag = a[31] ? 32'd0 - a : a;
        b_mag = b[31] ? 32'd0 - b : b;
        case (op)
            CH_PLUS:  return a + b;
            CH_MINUS: return a - b;
            CH_STAR:  return a * b;
            default:
            begin
                quo = a_mag / b_mag;
                return (a[31] ^ b[31]) ? 32'd0 - quo : quo;
            end
        endcase
    endfunction

    // Apply one accepted beat to the model; the final character yields a result
    function automatic void predict_beat(expr_t beat);
        logic [7:0]  c;
        logic [31:0] opa;
        logic [31:0] opb;
        result_t     res;
        c = beat.char_code;
        chars_taken++;
        if (calc_err == STAT_OK)
        begin
            if (is_digit(c))
            begin
                if (calc_depth >= DEPTH)
                    calc_err = STAT_OVERFLOW;
                else
                begin
                    calc_stack[calc_depth] = 32'(c) - 32'(CH_ZERO);
                    calc_depth++;
                end
            end
            else if (is_op_char(c))
            begin
                if (calc_depth < 2)
                    calc_err = STAT_FEW;
                else
                begin
                    opb = calc_stack[calc_depth - 1];
                    opa = calc_stack[calc_depth - 2];
                    calc_depth -= 2;
                    // operands are consumed even when the divisor is zero
                    if (c == CH_SLASH && opb == 32'd0)
                        calc_err = STAT_DIVZERO;
                    else
                    begin
                        calc_stack[calc_depth] = apply_operator(c, opa, opb);
                        calc_depth++;
                    end
                end
            end
        end
        if (beat.end_of_expr)
        begin
            res.value = '0;
            if (calc_err != STAT_OK)
                res.status = calc_err;
            else if (calc_depth == 0)
                res.status = STAT_EMPTY;
            else if (calc_depth > 1)
                res.status = STAT_MALFORMED;
            else
            begin
                res.status = STAT_OK;
                res.value  = calc_stack[0];
            end
            expected_results = {expected_results, res};
            calc_depth = 0;
            calc_err   = STAT_OK;
        end
    endfunction

    // Stimulus helpers
    function automatic logic [7:0] digit_char(int d);
        return 8'(CH_ZERO + d);
    endfunction

    function automatic logic [7:0] random_digit();
        return digit_char($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] random_ignored();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_digit(c) || is_op_char(c));
        return c;
    endfunction

    // Queue one expression; the last character carries the end mark
    function automatic void queue_expr(byte unsigned chars [$], bit drain);
        char_item_t item;
        foreach (chars[i])
        begin
            item.beat.char_code   = chars[i];
            item.beat.end_of_expr = (i == chars.size() - 1);
            item.drain            = drain && (i == 0);
            pending = {pending, item};
        end
        expr_count++;
    endfunction

    function automatic void queue_text(string s);
        byte unsigned chars [$];
        for (int i = 0; i < s.len(); i++)
            chars = {chars, s[i]};
        queue_expr(chars, 1'b0);
    endfunction

    // Well-formed postfix with n_ops operators; deep fills the stack first
    function automatic void build_wellformed(ref byte unsigned chars [$], input int n_ops,
                                             input bit deep);
        int digits_left;
        int ops_left;
        int depth;
        bit do_push;
        digits_left = n_ops + 1;
        ops_left    = n_ops;
        depth       = 0;
        while (digits_left + ops_left > 0)
        begin
            if (digits_left == 0 || depth >= DEPTH)
                do_push = 1'b0;
            else if (ops_left == 0 || depth < 2)
                do_push = 1'b1;
            else
                do_push = deep ? 1'b1 : ($urandom_range(0, 1) == 1);
            if (do_push)
            begin
                chars = {chars, random_digit()};
                depth++;
                digits_left--;
            end
            else
            begin
                chars = {chars, random_operator()};
                depth--;
                ops_left--;
            end
            if ($urandom_range(0, 9) == 0)
                chars = {chars, random_ignored()};
        end
    endfunction

    function automatic void queue_random_expr(bit drain);
        byte unsigned chars [$];
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            build_wellformed(chars, $urandom_range(0, 6), 1'b0);
        end
        else if (kind < 63)
        begin
            build_wellformed(chars, DEPTH - 1, 1'b1);
        end
        else if (kind < 68)
        begin
            // product chain that can wrap around 32 bits
            chars = {chars, digit_char(9)};
            repeat ($urandom_range(4, 14))
            begin
                chars = {chars, digit_char($urandom_range(2, 9))};
                chars = {chars, CH_STAR};
            end
            if ($urandom_range(0, 1) == 1)
            begin
                chars = {chars, random_digit()};
                chars = {chars, random_operator()};
            end
        end
        else if (kind < 72)
        begin
            // 8^10 * 2 wraps to the most negative value
            chars = {chars, digit_char(8)};
            repeat (9)
            begin
                chars = {chars, digit_char(8)};
                chars = {chars, CH_STAR};
            end
            chars = {chars, digit_char(2)};
            chars = {chars, CH_STAR};
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    // divided by -1
                    chars = {chars, digit_char(0)};
                    chars = {chars, digit_char(1)};
                    chars = {chars, CH_MINUS};
                    chars = {chars, CH_SLASH};
                end
                2:
                begin
                    chars = {chars, digit_char(1)};
                    chars = {chars, CH_MINUS};
                end
                default:
                begin
                    chars = {chars, digit_char(0)};
                    chars = {chars, digit_char(1)};
                    chars = {chars, CH_MINUS};
                    chars = {chars, CH_STAR};
                end
            endcase
        end
        else if (kind < 86)
        begin
            // broken expressions, then junk that a sticky error, where one is set, must swallow
            build_wellformed(chars, $urandom_range(0, 5), 1'b0);
            case ($urandom_range(0, 4))
                0: chars = {chars, random_operator()};
                1: chars = {chars, random_digit()};
                2: chars.push_front(random_operator());
                3:
                begin
                    chars = {chars, digit_char(0)};
                    chars = {chars, CH_SLASH};
                end
                default:
                begin
                    chars.delete();
                    repeat (DEPTH + $urandom_range(1, 3))
                        chars = {chars, random_digit()};
                end
            endcase
            repeat ($urandom_range(0, 4))
                chars = {chars, 8'($urandom_range(0, 255))};
        end
        else if (kind < 92)
        begin
            // nothing but ignored characters
            repeat ($urandom_range(1, 4))
                chars = {chars, random_ignored()};
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                chars = {chars, 8'($urandom_range(0, 255))};
        end
        if ($urandom_range(0, 5) == 0)
            chars = {chars, random_ignored()};
        queue_expr(chars, drain);
    endfunction

    // Input driver: presents pending beats, random gaps, optional drain pause
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expr_valid <= 1'b0;
            expr_data  <= '0;
            send_gap   <= 0;
        end
        else
        begin
            if (expr_valid && expr_ready)
                predict_beat(expr_data);
            if (expr_valid && !expr_ready)
            begin
                // hold the beat until it is taken
            end
            else if (send_gap != 0)
            begin
                expr_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (pending.size() != 0 &&
                     (!pending[0].drain || expected_results.size() == 0))
            begin
                if (pending.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                begin
                    expr_valid <= 1'b0;
                    send_gap   <= $urandom_range(0, 5);
                end
                else
                begin
                    expr_valid <= 1'b1;
                    expr_data  <= pending[0].beat;
                    pending.pop_front();
                end
            end
            else
            begin
                expr_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each beat with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_stall   <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                status_seen[result_data.status]++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got %0d status %0d",
                             $time, result_data.value, result_data.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_data.value !== want.value)
                    begin
                        mismatches++;
                        $display("%0t: result %0d value: expected %0d, got %0d",
                                 $time, results_seen, want.value, result_data.value);
                    end
                    if (result_data.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: result %0d status: expected %0d, got %0d",
                                 $time, results_seen, want.status, result_data.status);
                    end
                end
                results_seen++;
            end
            if (recv_stall != 0)
            begin
                result_ready <= 1'b0;
                recv_stall   <= recv_stall - 1;
            end
            else if (pending.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                recv_stall   <= $urandom_range(0, 5);
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus build, reset and end of run
    initial
    begin
        // basic operations and end conditions
        queue_text("9");
        queue_text("0");
        queue_text("12+");
        queue_text("93-");
        queue_text("39-");
        queue_text("99*");
        queue_text("72/");
        queue_text("50/");
        queue_text("+");
        queue_text("12");
        queue_text(" ");
        queue_random_expr(1'b1);
        while (pending.size() < NUM_ITEMS)
            queue_random_expr($urandom_range(0, 49) == 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || expr_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        $display("%0d expressions, %0d characters, %0d results checked", expr_count,
                 chars_taken, results_seen);
        $display("status mix: ok %0d, few %0d, malformed %0d, empty %0d,",
                 status_seen[STAT_OK], status_seen[STAT_FEW],
                 status_seen[STAT_MALFORMED], status_seen[STAT_EMPTY]);
        $display("            div0 %0d, overflow %0d",
                 status_seen[STAT_DIVZERO], status_seen[STAT_OVERFLOW]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
